>>> hw/rtl/signed_integer_to_radix_text_assert.svh
// Assertion macros for the radix text converter checker.
// Depends on nothing; taken in by the checker file with an include.
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SIRT_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SIRT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/sirt_pkg.sv
// Package of the radix text converter: widths, register codes, reset values.
// Used by the interfaces and by every module of the block.
`timescale 1ns / 1ps

package sirt_pkg;

  // Field widths
  localparam int VALUE_W   = 32;
  localparam int BYTE_W    = 8;
  localparam int RADIX_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;
  localparam int SYM_IDX_W = 4;

  // Defaults for the top-level parameters
  localparam int MAX_DIGITS_DEF = 32;
  localparam int MAX_RADIX_DEF  = 16;

  // Shared divider: quotient bits resolved per cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = VALUE_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI = 2'd2;

  // Reset values: radix ten, symbols "0123456789ABCDEF"
  localparam logic [RADIX_W-1:0]   RADIX_RST    = 5'd10;
  localparam logic [RADIX_W-1:0]   RADIX_MIN    = 5'd2;
  localparam logic [CFG_DAT_W-1:0] ALPHA_LO_RST = 64'h3736353433323130;
  localparam logic [CFG_DAT_W-1:0] ALPHA_HI_RST = 64'h4645444342413938;

  localparam logic [BYTE_W-1:0] MINUS_BYTE = 8'h2D;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

>>> hw/rtl/sirt_if.sv
// Channel interfaces of the radix text converter: input, result, configuration.
// Depends on sirt_pkg for the payload widths.
`timescale 1ns / 1ps

interface sirt_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [sirt_pkg::VALUE_W-1:0] value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

interface sirt_out_if;
  logic                        valid;
  logic                        ready;
  logic [sirt_pkg::BYTE_W-1:0] text_byte;
  logic                        last;

  modport source (output valid, text_byte, last, input ready);
  modport sink   (input valid, text_byte, last, output ready);
endinterface

interface sirt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sirt_pkg::CFG_IDX_W-1:0] index;
  logic [sirt_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/sirt_cfg_regs.sv
// Configuration registers: radix (clamped on write) and the two alphabet words.
// Depends on sirt_pkg and sirt_cfg_if.
`timescale 1ns / 1ps

module sirt_cfg_regs #(
  parameter int MAX_RADIX = sirt_pkg::MAX_RADIX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sirt_cfg_if.sink                       cfg_ch,
  output logic [sirt_pkg::RADIX_W-1:0]   radix,
  output logic [sirt_pkg::CFG_DAT_W-1:0] alpha_lo,
  output logic [sirt_pkg::CFG_DAT_W-1:0] alpha_hi
);

  localparam int RW = sirt_pkg::RADIX_W;
  localparam logic [RW-1:0] RADIX_MAX = RW'(MAX_RADIX);

  logic [RW-1:0]                  radix_r, radix_nxt;
  logic [sirt_pkg::CFG_DAT_W-1:0] alpha_lo_r, alpha_hi_r;
  logic                           wr;

  // Writes are taken every cycle
  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid;

  // Clamp the written radix into the supported range
  always_comb begin
    radix_nxt = cfg_ch.data[RW-1:0];
    if (radix_nxt < sirt_pkg::RADIX_MIN) begin
      radix_nxt = sirt_pkg::RADIX_MIN;
    end else if (radix_nxt > RADIX_MAX) begin
      radix_nxt = RADIX_MAX;
    end
  end

  // Decode the register index; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= sirt_pkg::RADIX_RST;
      alpha_lo_r <= sirt_pkg::ALPHA_LO_RST;
      alpha_hi_r <= sirt_pkg::ALPHA_HI_RST;
    end else if (wr) begin
      unique case (cfg_ch.index)
        sirt_pkg::CFG_RADIX:    radix_r    <= radix_nxt;
        sirt_pkg::CFG_ALPHA_LO: alpha_lo_r <= cfg_ch.data;
        sirt_pkg::CFG_ALPHA_HI: alpha_hi_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign radix    = radix_r;
  assign alpha_lo = alpha_lo_r;
  assign alpha_hi = alpha_hi_r;

endmodule

>>> hw/rtl/sirt_divider.sv
// Shared divider: 32-bit magnitude by the radix, eight quotient bits a cycle.
// Depends on sirt_pkg. Quotient and remainder are valid on the done pulse.
`timescale 1ns / 1ps

module sirt_divider #(
  parameter int DIGIT_W = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sirt_pkg::VALUE_W-1:0] dividend,
  input  logic [sirt_pkg::RADIX_W-1:0] divisor,
  output sirt_pkg::div_sts_t           sts,
  output logic [sirt_pkg::VALUE_W-1:0] quotient,
  output logic [DIGIT_W-1:0]           remainder
);

  localparam int W  = sirt_pkg::VALUE_W;
  localparam int RW = sirt_pkg::RADIX_W;
  localparam int SW = sirt_pkg::STEP_W;
  localparam logic [SW-1:0] STEP_LAST = SW'(sirt_pkg::DIV_STEPS - 1);

  logic [W-1:0]       work_r, work_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [SW-1:0]      step_r;
  logic               busy_r, done_r;

  // One slice of restoring long division
  always_comb begin
    logic [W-1:0]       work;
    logic [DIGIT_W-1:0] rem;
    logic [DIGIT_W:0]   part;
    logic [RW-1:0]      diff;
    work = work_r;
    rem  = rem_r;
    for (int i = 0; i < sirt_pkg::DIV_BITS; i++) begin
      part = {rem, work[W-1]};
      diff = RW'(part) - divisor;
      work = {work[W-2:0], 1'b0};
      if (RW'(part) >= divisor) begin
        rem     = diff[DIGIT_W-1:0];
        work[0] = 1'b1;
      end else begin
        rem = part[DIGIT_W-1:0];
      end
    end
    work_nxt = work;
    rem_nxt  = rem;
  end

  // Step count and status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Working registers: load on start, advance while busy
  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= dividend;
      rem_r  <= '0;
    end else if (busy_r) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = work_r;
  assign remainder = rem_r;

endmodule

>>> hw/rtl/signed_integer_to_radix_text.sv
// Signed integer to radix text. Takes one signed 32-bit value and sends its
// text, most significant digit first, one byte per result transfer, with a
// leading minus byte for negative values and last set on the final byte.
// The radix (2 to MAX_RADIX) and the 16-symbol alphabet are configuration
// registers; the user must write them only while the block is idle, which
// the block itself does not enforce. One value is converted at a time:
// in_ch.ready is low from the accepted value until its last byte sits in
// the output register. Digits come from one shared divider that resolves
// eight quotient bits per cycle; after each division the remainder is
// pushed onto the stack. Values needing more than MAX_DIGITS digits keep
// only the least significant MAX_DIGITS digits.
// Depends on sirt_pkg, sirt_if, sirt_cfg_regs and sirt_divider.
`timescale 1ns / 1ps

module signed_integer_to_radix_text #(
  parameter int MAX_DIGITS = sirt_pkg::MAX_DIGITS_DEF,
  parameter int MAX_RADIX  = sirt_pkg::MAX_RADIX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sirt_in_if.sink    in_ch,
  sirt_out_if.source out_ch,
  sirt_cfg_if.sink   cfg_ch
);

  localparam int W       = sirt_pkg::VALUE_W;
  localparam int BW      = sirt_pkg::BYTE_W;
  localparam int SIW     = sirt_pkg::SYM_IDX_W;
  localparam int DIGIT_W = $clog2(MAX_RADIX);
  localparam int ADDR_W  = $clog2(MAX_DIGITS);
  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_PRIME = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [sirt_pkg::RADIX_W-1:0]   radix;
  logic [sirt_pkg::CFG_DAT_W-1:0] alpha_lo, alpha_hi;

  logic                     div_start;
  logic [W-1:0]             dividend, mag, quotient;
  logic [DIGIT_W-1:0]       remainder;
  sirt_pkg::div_sts_t       div_sts;

  logic [CNT_W-1:0]         cnt_r, cnt_nxt, cnt_inc, cnt_dec;
  logic                     neg_r, neg_nxt;
  logic                     in_acc, slot_free;

  logic [DIGIT_W-1:0]       stack [MAX_DIGITS];
  logic [DIGIT_W-1:0]       rd_data_r;
  logic                     wr_en, rd_en;

  logic                     out_valid_r, out_last_r;
  logic [BW-1:0]            out_byte_r;
  logic                     load_out, load_last;
  logic [BW-1:0]            load_byte;

  // Map a digit to its alphabet byte
  function automatic logic [BW-1:0] symbol_of(input logic [SIW-1:0] d,
                                              input logic [sirt_pkg::CFG_DAT_W-1:0] lo,
                                              input logic [sirt_pkg::CFG_DAT_W-1:0] hi);
    logic [sirt_pkg::CFG_DAT_W-1:0] word;
    word = d[SIW-1] ? hi : lo;
    word = word >> {d[SIW-2:0], 3'b000};
    return word[BW-1:0];
  endfunction

  sirt_cfg_regs #(
    .MAX_RADIX (MAX_RADIX)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_ch   (cfg_ch),
    .radix    (radix),
    .alpha_lo (alpha_lo),
    .alpha_hi (alpha_hi)
  );

  sirt_divider #(
    .DIGIT_W (DIGIT_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (radix),
    .sts       (div_sts),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Input side: magnitude of the incoming value
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && (state_r == ST_IDLE);
  assign mag         = in_ch.value[W-1] ? (W'(0) - W'(in_ch.value)) : W'(in_ch.value);
  assign dividend    = (state_r == ST_IDLE) ? mag : quotient;

  assign cnt_inc   = cnt_r + 1'b1;
  assign cnt_dec   = cnt_r - 1'b1;
  assign slot_free = !out_valid_r || out_ch.ready;

  // Sequencer: divide into the stack, then pop digits out most significant first
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    div_start = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    load_byte = '0;
    load_last = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          div_start = 1'b1;
          cnt_nxt   = '0;
          neg_nxt   = in_ch.value[W-1];
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_inc;
          if ((quotient != '0) && (cnt_inc < CNT_W'(MAX_DIGITS))) begin
            div_start = 1'b1;
          end else begin
            state_nxt = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        rd_en     = 1'b1;
        cnt_nxt   = cnt_dec;
        state_nxt = neg_r ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (slot_free) begin
          load_out  = 1'b1;
          load_byte = sirt_pkg::MINUS_BYTE;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          load_out  = 1'b1;
          load_byte = symbol_of(SIW'(rd_data_r), alpha_lo, alpha_hi);
          load_last = (cnt_r == '0);
          if (cnt_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            cnt_nxt = cnt_dec;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      neg_r   <= neg_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Digit stack: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack[cnt_r[ADDR_W-1:0]] <= remainder;
    end
    if (rd_en) begin
      rd_data_r <= stack[cnt_dec[ADDR_W-1:0]];
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte_r <= load_byte;
      out_last_r <= load_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.text_byte = out_byte_r;
  assign out_ch.last      = out_last_r;

endmodule

>>> hw/rtl/sirt_checker.sv
// Port-level checker for the radix text converter, bound to the top level.
// Depends on the assertion macro header and on the top level's channel ports.
`timescale 1ns / 1ps
`include "signed_integer_to_radix_text_assert.svh"

module sirt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sirt_pkg::BYTE_W-1:0] out_text_byte,
  input logic                        out_last
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // A stalled result holds its byte and marker
  `SIRT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_text_byte) && $stable(out_last), "stalled result changed")
  // One value at a time: busy right after a transfer in
  `SIRT_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_xfer, !in_ready, "input taken while converting")
  // No byte can appear the cycle after a value is taken
  `SIRT_ASSERT_NEXT(a_no_early_byte, clk, rst_n, in_xfer, !$rose(out_valid), "result too early")
  // While a non-final byte waits, the input side stays closed
  `SIRT_ASSERT_SAME(a_text_closed, clk, rst_n, out_valid && !out_last, !in_ready, "ready during text")

endmodule

bind signed_integer_to_radix_text sirt_checker u_sirt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_text_byte (out_ch.text_byte),
  .out_last      (out_ch.last)
);
